// ----- design/dlcq_pkg.sv -----
package dlcq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = 32 + PTR_W + 1;
    localparam int TAG_W       = 16;
    localparam int DELAY_W     = 31;
    localparam int VAL_W       = 32;

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_INSERT   = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_EXPIRED   = 3'd0,
        KIND_INSERTED  = 3'd1,
        KIND_OVERFLOW  = 3'd2,
        KIND_REMOVED   = 3'd3,
        KIND_NOT_FOUND = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CUR_KEEP,
        CUR_HEAD,
        CUR_FREE,
        CUR_LINK
    } cur_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OVF,
        ST_TDEC,
        ST_TSCAN,
        ST_IALLOC,
        ST_IWALK,
        ST_ILINK,
        ST_IFIN,
        ST_RWALK,
        ST_RMISS,
        ST_RUNLINK,
        ST_RFREE
    } state_t;

    typedef struct packed {
        logic     load;
        cur_sel_t cur_sel;
        logic     prev_step;
        logic     tdec;
        logic     ialloc;
        logic     iwalk;
        logic     ilink;
        logic     ifin;
        logic     rstep;
        logic     rmatch;
        logic     runlink;
        logic     rfree;
        logic     tpop;
        logic     send;
        kind_t    kind;
        logic     last;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_nil;
        logic free_nil;
        logic dec_nonneg;
        logic walk_go;
        logic tag_hit;
        logic due;
        logic pend;
        logic allow;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/dlcq_ctrl.sv -----
module dlcq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_opcode,
    input  dlcq_pkg::dp_status_t status,
    output logic                 s_ready,
    output dlcq_pkg::dp_cmd_t    cmd
);

    dlcq_pkg::state_t state_reg;
    dlcq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dlcq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dlcq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        dlcq_pkg::OP_TICK:   state_next = dlcq_pkg::ST_TDEC;
                        dlcq_pkg::OP_INSERT: state_next = status.free_nil ?
                                                 dlcq_pkg::ST_OVF : dlcq_pkg::ST_IALLOC;
                        dlcq_pkg::OP_REMOVE: state_next = dlcq_pkg::ST_RWALK;
                        default:             state_next = dlcq_pkg::ST_IDLE;
                    endcase
                end
            end
            dlcq_pkg::ST_OVF: begin
                if (status.out_free) state_next = dlcq_pkg::ST_IDLE;
            end
            dlcq_pkg::ST_TDEC: begin
                if (status.cur_nil || status.dec_nonneg) state_next = dlcq_pkg::ST_TSCAN;
            end
            dlcq_pkg::ST_TSCAN: begin
                if (!status.allow) begin
                    state_next = dlcq_pkg::ST_IDLE;
                end else if (!(status.pend && !status.out_free) && !status.due) begin
                    state_next = dlcq_pkg::ST_IDLE;
                end
            end
            dlcq_pkg::ST_IALLOC:  state_next = dlcq_pkg::ST_IWALK;
            dlcq_pkg::ST_IWALK: begin
                if (!status.walk_go) state_next = dlcq_pkg::ST_ILINK;
            end
            dlcq_pkg::ST_ILINK:   state_next = dlcq_pkg::ST_IFIN;
            dlcq_pkg::ST_IFIN: begin
                if (status.out_free) state_next = dlcq_pkg::ST_IDLE;
            end
            dlcq_pkg::ST_RWALK: begin
                if (status.cur_nil) begin
                    state_next = dlcq_pkg::ST_RMISS;
                end else if (status.tag_hit) begin
                    state_next = dlcq_pkg::ST_RUNLINK;
                end
            end
            dlcq_pkg::ST_RMISS: begin
                if (status.out_free) state_next = dlcq_pkg::ST_IDLE;
            end
            dlcq_pkg::ST_RUNLINK: state_next = dlcq_pkg::ST_RFREE;
            dlcq_pkg::ST_RFREE: begin
                if (status.out_free) state_next = dlcq_pkg::ST_IDLE;
            end
            default: state_next = dlcq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            dlcq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.cur_sel = (s_opcode == dlcq_pkg::OP_INSERT) ?
                                  dlcq_pkg::CUR_FREE : dlcq_pkg::CUR_HEAD;
                end
            end
            dlcq_pkg::ST_OVF: begin
                cmd.kind = dlcq_pkg::KIND_OVERFLOW;
                cmd.last = 1'b1;
                cmd.send = status.out_free;
            end
            dlcq_pkg::ST_TDEC: begin
                if (status.cur_nil) begin
                    cmd.cur_sel = dlcq_pkg::CUR_HEAD;
                end else begin
                    cmd.tdec    = 1'b1;
                    cmd.cur_sel = status.dec_nonneg ? dlcq_pkg::CUR_HEAD : dlcq_pkg::CUR_LINK;
                end
            end
            dlcq_pkg::ST_TSCAN: begin
                cmd.kind = dlcq_pkg::KIND_EXPIRED;
                cmd.last = !status.due;
                // hold while a pending expiry cannot leave yet
                if (status.allow && !(status.pend && !status.out_free)) begin
                    cmd.send = status.pend;
                    if (status.due) begin
                        cmd.tpop    = 1'b1;
                        cmd.cur_sel = dlcq_pkg::CUR_LINK;
                    end
                end
            end
            dlcq_pkg::ST_IALLOC: begin
                cmd.ialloc  = 1'b1;
                cmd.cur_sel = dlcq_pkg::CUR_HEAD;
            end
            dlcq_pkg::ST_IWALK: begin
                if (status.walk_go) begin
                    cmd.iwalk   = 1'b1;
                    cmd.cur_sel = dlcq_pkg::CUR_LINK;
                end
            end
            dlcq_pkg::ST_ILINK: cmd.ilink = 1'b1;
            dlcq_pkg::ST_IFIN: begin
                cmd.kind = dlcq_pkg::KIND_INSERTED;
                cmd.last = 1'b1;
                cmd.ifin = status.out_free;
                cmd.send = status.out_free;
            end
            dlcq_pkg::ST_RWALK: begin
                if (!status.cur_nil) begin
                    cmd.rstep   = 1'b1;
                    cmd.cur_sel = dlcq_pkg::CUR_LINK;
                    if (status.tag_hit) begin
                        cmd.rmatch = 1'b1;
                    end else begin
                        cmd.prev_step = 1'b1;
                    end
                end
            end
            dlcq_pkg::ST_RMISS: begin
                cmd.kind = dlcq_pkg::KIND_NOT_FOUND;
                cmd.last = 1'b1;
                cmd.send = status.out_free;
            end
            dlcq_pkg::ST_RUNLINK: cmd.runlink = 1'b1;
            dlcq_pkg::ST_RFREE: begin
                cmd.kind  = dlcq_pkg::KIND_REMOVED;
                cmd.last  = 1'b1;
                cmd.rfree = status.out_free;
                cmd.send  = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- design/dlcq_dp.sv -----
module dlcq_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dlcq_pkg::dp_cmd_t             cmd,
    input  logic [dlcq_pkg::TAG_W-1:0]    s_timer_tag,
    input  logic [dlcq_pkg::DELAY_W-1:0]  s_delay_ticks,
    input  logic                          s_dispatch_allowed,
    input  logic                          m_ready,
    output dlcq_pkg::dp_status_t          status,
    output logic                          m_valid,
    output logic [2:0]                    m_result_kind,
    output logic [dlcq_pkg::TAG_W-1:0]    m_result_tag,
    output logic signed [dlcq_pkg::VAL_W-1:0] m_result_value,
    output logic                          m_last_result
);

    localparam int DEPTH = dlcq_pkg::QUEUE_DEPTH;
    localparam int IW    = dlcq_pkg::IDX_W;
    localparam int PW    = dlcq_pkg::PTR_W;
    localparam int SW    = dlcq_pkg::SUM_W;
    localparam int VW    = dlcq_pkg::VAL_W;
    localparam int TW    = dlcq_pkg::TAG_W;

    localparam logic signed [VW-1:0] VAL_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_ZERO = {VW{1'b0}};

    function automatic logic signed [VW-1:0] sat_val(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        lo = SW'(VAL_MIN);
        hi = SW'(VAL_MAX);
        if (v > hi) return VAL_MAX;
        if (v < lo) return VAL_MIN;
        return v[VW-1:0];
    endfunction

    logic signed [VW-1:0] delta_mem [DEPTH];
    logic [TW-1:0]        tag_mem   [DEPTH];
    logic [PW-1:0]        link_mem  [DEPTH];

    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        free_reg, free_next;
    logic [PW-1:0]        cur_reg,  cur_next;
    logic [PW-1:0]        prev_reg, prev_next;
    logic [PW-1:0]        e_reg,    e_next;
    logic signed [VW-1:0] t_reg,    t_next;
    logic signed [VW-1:0] d_reg,    d_next;
    logic signed [SW-1:0] sum_reg,  sum_next;
    logic [TW-1:0]        tag_reg,  tag_next;
    logic                 allow_reg, allow_next;
    logic                 pend_reg, pend_next;
    logic [TW-1:0]        pend_tag_reg, pend_tag_next;
    logic signed [VW-1:0] pend_val_reg, pend_val_next;
    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           kind_reg, kind_next;
    logic [TW-1:0]        otag_reg, otag_next;
    logic signed [VW-1:0] oval_reg, oval_next;
    logic                 olast_reg, olast_next;

    logic [IW-1:0]        cur_idx;
    logic signed [VW-1:0] rd_delta;
    logic [TW-1:0]        rd_tag;
    logic [PW-1:0]        rd_link;
    logic signed [VW-1:0] dec_val;
    logic signed [VW-1:0] sub_val;
    logic signed [VW-1:0] add_val;
    logic                 cur_nil;
    logic                 prev_nil;
    logic                 out_free;

    logic                 link_we;
    logic [IW-1:0]        link_wa;
    logic [PW-1:0]        link_wd;
    logic                 delta_we;
    logic [IW-1:0]        delta_wa;
    logic signed [VW-1:0] delta_wd;

    assign cur_idx  = cur_reg[IW-1:0];
    assign rd_delta = delta_mem[cur_idx];
    assign rd_tag   = tag_mem[cur_idx];
    assign rd_link  = link_mem[cur_idx];
    assign cur_nil  = (cur_reg == dlcq_pkg::NIL_PTR);
    assign prev_nil = (prev_reg == dlcq_pkg::NIL_PTR);
    assign out_free = !m_valid_reg || m_ready;

    // decrement floors at the most negative value
    assign dec_val = (rd_delta == VAL_MIN) ? rd_delta : rd_delta - VW'(1);
    assign sub_val = sat_val(SW'(rd_delta) - SW'(t_reg));
    assign add_val = sat_val(SW'(rd_delta) + SW'(d_reg));

    always_comb begin
        status            = '0;
        status.cur_nil    = cur_nil;
        status.free_nil   = (free_reg == dlcq_pkg::NIL_PTR);
        status.dec_nonneg = !dec_val[VW-1];
        status.walk_go    = !cur_nil && (rd_delta < t_reg);
        status.tag_hit    = (rd_tag == tag_reg);
        status.due        = !cur_nil && (rd_delta <= VAL_ZERO);
        status.pend       = pend_reg;
        status.allow      = allow_reg;
        status.out_free   = out_free;
    end

    always_comb begin
        link_we = 1'b0;
        link_wa = '0;
        link_wd = dlcq_pkg::NIL_PTR;
        if (cmd.ilink && !prev_nil) begin
            link_we = 1'b1;
            link_wa = prev_reg[IW-1:0];
            link_wd = e_reg;
        end else if (cmd.runlink && !prev_nil) begin
            link_we = 1'b1;
            link_wa = prev_reg[IW-1:0];
            link_wd = cur_reg;
        end else if (cmd.ifin) begin
            link_we = 1'b1;
            link_wa = e_reg[IW-1:0];
            link_wd = cur_reg;
        end else if (cmd.rfree) begin
            link_we = 1'b1;
            link_wa = e_reg[IW-1:0];
            link_wd = free_reg;
        end else if (cmd.tpop) begin
            link_we = 1'b1;
            link_wa = cur_idx;
            link_wd = free_reg;
        end
    end

    always_comb begin
        delta_we = 1'b0;
        delta_wa = cur_idx;
        delta_wd = dec_val;
        if (cmd.tdec) begin
            delta_we = 1'b1;
        end else if (cmd.ilink && !cur_nil) begin
            delta_we = 1'b1;
            delta_wd = sub_val;
        end else if (cmd.ifin) begin
            delta_we = 1'b1;
            delta_wa = e_reg[IW-1:0];
            delta_wd = t_reg;
        end else if (cmd.runlink && !cur_nil && (d_reg > VAL_ZERO)) begin
            delta_we = 1'b1;
            delta_wd = add_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (delta_we) delta_mem[delta_wa] <= delta_wd;
        if (cmd.ialloc) tag_mem[cur_idx] <= tag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                link_mem[i] <= (i + 1 < DEPTH) ? PW'(i + 1) : dlcq_pkg::NIL_PTR;
            end
        end else if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_comb begin
        head_next     = head_reg;
        free_next     = free_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        e_next        = e_reg;
        t_next        = t_reg;
        d_next        = d_reg;
        sum_next      = sum_reg;
        tag_next      = tag_reg;
        allow_next    = allow_reg;
        pend_next     = pend_reg;
        pend_tag_next = pend_tag_reg;
        pend_val_next = pend_val_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        otag_next     = otag_reg;
        oval_next     = oval_reg;
        olast_next    = olast_reg;

        if (cmd.load) begin
            tag_next   = s_timer_tag;
            allow_next = s_dispatch_allowed;
            prev_next  = dlcq_pkg::NIL_PTR;
            sum_next   = '0;
            t_next     = (s_delay_ticks == '0) ? VW'(1) : VW'(s_delay_ticks);
        end

        if (cmd.ialloc) begin
            e_next    = cur_reg;
            free_next = rd_link;
        end
        if (cmd.iwalk) begin
            if (rd_delta > VAL_ZERO) t_next = t_reg - rd_delta;
            prev_next = cur_reg;
        end
        if (cmd.prev_step) prev_next = cur_reg;
        if (cmd.ilink && prev_nil) head_next = e_reg;

        if (cmd.rstep) sum_next = sum_reg + SW'(rd_delta);
        if (cmd.rmatch) begin
            e_next = cur_reg;
            d_next = rd_delta;
        end
        if (cmd.runlink && prev_nil) head_next = cur_reg;
        if (cmd.rfree) free_next = e_reg;

        if (cmd.tpop) begin
            head_next     = rd_link;
            free_next     = cur_reg;
            pend_tag_next = rd_tag;
            pend_val_next = rd_delta;
        end
        if (cmd.tpop) begin
            pend_next = 1'b1;
        end else if (cmd.send) begin
            pend_next = 1'b0;
        end

        case (cmd.cur_sel)
            dlcq_pkg::CUR_HEAD: cur_next = head_reg;
            dlcq_pkg::CUR_FREE: cur_next = free_reg;
            dlcq_pkg::CUR_LINK: cur_next = rd_link;
            default:            cur_next = cur_reg;
        endcase

        if (cmd.send) begin
            m_valid_next = 1'b1;
            kind_next    = cmd.kind;
            olast_next   = cmd.last;
            otag_next    = (cmd.kind == dlcq_pkg::KIND_EXPIRED) ? pend_tag_reg : tag_reg;
            case (cmd.kind)
                dlcq_pkg::KIND_EXPIRED: oval_next = pend_val_reg;
                dlcq_pkg::KIND_REMOVED: oval_next = sat_val(sum_reg);
                default:                oval_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= dlcq_pkg::NIL_PTR;
            free_reg    <= '0;
            cur_reg     <= dlcq_pkg::NIL_PTR;
            prev_reg    <= dlcq_pkg::NIL_PTR;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            free_reg    <= free_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg        <= e_next;
        t_reg        <= t_next;
        d_reg        <= d_next;
        sum_reg      <= sum_next;
        tag_reg      <= tag_next;
        allow_reg    <= allow_next;
        pend_tag_reg <= pend_tag_next;
        pend_val_reg <= pend_val_next;
        kind_reg     <= kind_next;
        otag_reg     <= otag_next;
        oval_reg     <= oval_next;
        olast_reg    <= olast_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_result_tag   = otag_reg;
    assign m_result_value = oval_reg;
    assign m_last_result  = olast_reg;

endmodule

// ----- design/delta_list_callout_queue_core.sv -----
// Timer queue kept as an ordered delta list over a pool of 32 entries with a
// free list. Requests are handled one at a time by a sequencer that walks the
// linked entries through a single read port, one entry per cycle unless a
// stalled result holds it. Insert allocates, walks past earlier entries, links
// and reports; remove walks to the match, unlinks and frees it, or reports a
// miss at the list end; tick decrements from the head until a delta stays
// non-negative, then dispatches due entries when allowed. The worst case is a
// dispatching tick over a full pool of due entries. A result register decouples
// the output; a stalled result holds the walk at its sending step.
module delta_list_callout_queue_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_opcode,
    input  logic [dlcq_pkg::TAG_W-1:0]            s_timer_tag,
    input  logic [dlcq_pkg::DELAY_W-1:0]          s_delay_ticks,
    input  logic                                  s_dispatch_allowed,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_result_kind,
    output logic [dlcq_pkg::TAG_W-1:0]            m_result_tag,
    output logic signed [dlcq_pkg::VAL_W-1:0]     m_result_value,
    output logic                                  m_last_result
);

    dlcq_pkg::dp_cmd_t    cmd;
    dlcq_pkg::dp_status_t status;

    dlcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .status   (status),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    dlcq_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_timer_tag        (s_timer_tag),
        .s_delay_ticks      (s_delay_ticks),
        .s_dispatch_allowed (s_dispatch_allowed),
        .m_ready            (m_ready),
        .status             (status),
        .m_valid            (m_valid),
        .m_result_kind      (m_result_kind),
        .m_result_tag       (m_result_tag),
        .m_result_value     (m_result_value),
        .m_last_result      (m_last_result)
    );

    // an unused opcode returns straight to idle
    a_reserved_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == dlcq_pkg::OP_RESERVED) |=> s_ready)
        else $error("reserved opcode did not return to idle");

    // every result other than an expiry ends its request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != dlcq_pkg::KIND_EXPIRED) |-> m_last_result)
        else $error("single result request not marked last");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == dlcq_pkg::KIND_INSERTED ||
                     m_result_kind == dlcq_pkg::KIND_OVERFLOW ||
                     m_result_kind == dlcq_pkg::KIND_NOT_FOUND)) |-> m_result_value == '0)
        else $error("nonzero value on insert, overflow or miss");

    a_lateness_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == dlcq_pkg::KIND_EXPIRED) |->
        (m_result_value[dlcq_pkg::VAL_W-1] || m_result_value == '0))
        else $error("expiry with positive lateness");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int NIL = dlcq_pkg::QUEUE_DEPTH;
    localparam int MAX_DISPATCH = 32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] tag;
        logic [31:0] value;
        logic        last;
    } timer_event_t;

    typedef struct {
        dlcq_pkg::opcode_t op;
        logic [15:0]  tag;
        logic [30:0]  delay;
        logic         allow;
        bit           has_fixed;
        timer_event_t fixed;
    } request_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [15:0] s_timer_tag;
    logic [30:0] s_delay_ticks;
    logic        s_dispatch_allowed;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_result_kind;
    logic [15:0] m_result_tag;
    logic signed [31:0] m_result_value;
    logic        m_last_result;

    delta_list_callout_queue_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_timer_tag       (s_timer_tag),
        .s_delay_ticks     (s_delay_ticks),
        .s_dispatch_allowed(s_dispatch_allowed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_result_tag      (m_result_tag),
        .m_result_value    (m_result_value),
        .m_last_result     (m_last_result)
    );

    // timer pool mirror
    int          q_delta [dlcq_pkg::QUEUE_DEPTH];
    logic [15:0] q_tag   [dlcq_pkg::QUEUE_DEPTH];
    int          q_link  [dlcq_pkg::QUEUE_DEPTH];
    int          q_head;
    int          q_free;

    timer_event_t pending_events[$];
    int  error_count;
    int  event_count;
    int  expired_count;
    int  overflow_count;
    int  removed_count;
    bit  m_stall_on;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int next_of(int e);
        if (e >= NIL) return NIL;
        return q_link[e] >= NIL ? NIL : q_link[e];
    endfunction

    task automatic pool_reset();
        for (int i = 0; i < dlcq_pkg::QUEUE_DEPTH; i++) begin
            q_delta[i] = 0;
            q_tag[i]   = '0;
            q_link[i]  = (i + 1 < dlcq_pkg::QUEUE_DEPTH) ? i + 1 : NIL;
        end
        q_head = NIL;
        q_free = 0;
    endtask

    function automatic timer_event_t make_event(dlcq_pkg::kind_t k, logic [15:0] tg, int v);
        timer_event_t ev;
        ev.kind  = k;
        ev.tag   = tg;
        ev.value = v;
        ev.last  = 1'b0;
        return ev;
    endfunction

    // compute the events caused by one request and advance the mirror
    task automatic predict_timer_events(dlcq_pkg::opcode_t op, logic [15:0] tg,
                                        logic [30:0] dly, logic allow,
                                        output timer_event_t evs[$]);
        int p, g, t, prev, cur, e, nx;
        longint sum;
        bit hit;
        evs = {};
        case (op)
            dlcq_pkg::OP_TICK: begin
                p = q_head;
                g = 0;
                while (p < NIL && g < dlcq_pkg::QUEUE_DEPTH) begin
                    if (q_delta[p] != 32'h80000000) q_delta[p]--;
                    if (q_delta[p] >= 0) break;
                    p = next_of(p);
                    g++;
                end
                if (allow) begin
                    while (evs.size() < MAX_DISPATCH && q_head < NIL && q_delta[q_head] <= 0) begin
                        e = q_head;
                        evs.push_back(make_event(dlcq_pkg::KIND_EXPIRED, q_tag[e], q_delta[e]));
                        q_head = next_of(e);
                        q_link[e] = q_free;
                        q_free = e;
                    end
                end
            end
            dlcq_pkg::OP_INSERT: begin
                t = int'({1'b0, dly});
                if (t <= 0) t = 1;
                if (q_free >= NIL) begin
                    evs.push_back(make_event(dlcq_pkg::KIND_OVERFLOW, tg, 0));
                end else begin
                    e = q_free;
                    q_free = next_of(e);
                    q_tag[e] = tg;
                    prev = NIL;
                    cur = q_head;
                    g = 0;
                    while (cur < NIL && g < dlcq_pkg::QUEUE_DEPTH && q_delta[cur] < t) begin
                        if (q_delta[cur] > 0) t -= q_delta[cur];
                        prev = cur;
                        cur = next_of(cur);
                        g++;
                    end
                    if (prev < NIL) q_link[prev] = e;
                    else q_head = e;
                    q_link[e] = cur;
                    q_delta[e] = t;
                    if (cur < NIL) q_delta[cur] = clamp32(longint'(q_delta[cur]) - t);
                    evs.push_back(make_event(dlcq_pkg::KIND_INSERTED, tg, 0));
                end
            end
            dlcq_pkg::OP_REMOVE: begin
                prev = NIL;
                cur = q_head;
                sum = 0;
                g = 0;
                hit = 1'b0;
                while (cur < NIL && g < dlcq_pkg::QUEUE_DEPTH && !hit) begin
                    sum += q_delta[cur];
                    if (q_tag[cur] == tg) begin
                        hit = 1'b1;
                        nx = next_of(cur);
                        if (nx < NIL && q_delta[cur] > 0)
                            q_delta[nx] = clamp32(longint'(q_delta[nx]) + q_delta[cur]);
                        if (prev < NIL) q_link[prev] = nx;
                        else q_head = nx;
                        q_link[cur] = q_free;
                        q_free = cur;
                        evs.push_back(make_event(dlcq_pkg::KIND_REMOVED, tg, clamp32(sum)));
                    end else begin
                        prev = cur;
                        cur = next_of(cur);
                        g++;
                    end
                end
                if (!hit) evs.push_back(make_event(dlcq_pkg::KIND_NOT_FOUND, tg, 0));
            end
            default: ;
        endcase
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(negedge aclk);
    endtask

    // present one request, hold until accepted, queue its expected events
    task automatic send_request(dlcq_pkg::opcode_t op, logic [15:0] tg, logic [30:0] dly,
                                logic allow, bit has_fixed, timer_event_t fixed);
        timer_event_t evs[$];
        int gap;
        gap = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            wait_cycles(gap);
        end
        s_valid            <= 1'b1;
        s_opcode           <= op;
        s_timer_tag        <= tg;
        s_delay_ticks      <= dly;
        s_dispatch_allowed <= allow;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timer_events(op, tg, dly, allow, evs);
        if (has_fixed && (evs.size() != 1 || evs[0] != fixed)) begin
            $error("directed row disagrees with predictor: kind %0d tag %h", fixed.kind, fixed.tag);
            error_count++;
        end
        foreach (evs[i]) pending_events.push_back(evs[i]);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_events.size() != 0);
    endtask

    // result side: random stall per result, compare at the rising edge
    initial begin
        timer_event_t exp_ev;
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = m_stall_on ? $urandom_range(0, 9) : 0;
            repeat (gap) @(negedge aclk);
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            event_count++;
            if (pending_events.size() == 0) begin
                $error("unexpected result kind %0d tag %h", m_result_kind, m_result_tag);
                error_count++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_result_kind !== exp_ev.kind) begin
                    $error("result_kind expected %0d actual %0d", exp_ev.kind, m_result_kind);
                    error_count++;
                end
                if (m_result_tag !== exp_ev.tag) begin
                    $error("result_tag expected %h actual %h", exp_ev.tag, m_result_tag);
                    error_count++;
                end
                if (m_result_value !== exp_ev.value) begin
                    $error("result_value expected %0d actual %0d",
                           $signed(exp_ev.value), m_result_value);
                    error_count++;
                end
                if (m_last_result !== exp_ev.last) begin
                    $error("last_result expected %0b actual %0b", exp_ev.last, m_last_result);
                    error_count++;
                end
                if (exp_ev.kind == dlcq_pkg::KIND_EXPIRED) expired_count++;
                if (exp_ev.kind == dlcq_pkg::KIND_OVERFLOW) overflow_count++;
                if (exp_ev.kind == dlcq_pkg::KIND_REMOVED) removed_count++;
            end
            @(negedge aclk);
            m_ready <= 1'b0;
        end
    end

    function automatic request_row_t row(dlcq_pkg::opcode_t op, logic [15:0] tg,
                                         logic [30:0] dly, logic allow, bit has_fixed = 0,
                                         dlcq_pkg::kind_t k = dlcq_pkg::KIND_EXPIRED,
                                         int v = 0);
        request_row_t r;
        r.op = op;
        r.tag = tg;
        r.delay = dly;
        r.allow = allow;
        r.has_fixed = has_fixed;
        r.fixed = make_event(k, tg, v);
        r.fixed.last = 1'b1;
        return r;
    endfunction

    initial begin
        request_row_t rows[$];
        int n_items, r;
        logic [15:0] tg;
        logic [15:0] used_tags[$];
        error_count = 0;
        event_count = 0;
        expired_count = 0;
        overflow_count = 0;
        removed_count = 0;
        m_stall_on = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = dlcq_pkg::OP_TICK;
        s_timer_tag = '0;
        s_delay_ticks = '0;
        s_dispatch_allowed = 1'b0;
        pool_reset();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty queue, clamped delay, extremes, due chain, remove paths
        rows.push_back(row(dlcq_pkg::OP_REMOVE, 16'hffff, '0, 1'b0, 1,
                           dlcq_pkg::KIND_NOT_FOUND, 0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'h0000, '0, 1'b1));
        rows.push_back(row(dlcq_pkg::OP_RESERVED, 16'h1234, 31'h7fffffff, 1'b1));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'h0000, 31'd0, 1'b0, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'hffff, 31'h7fffffff, 1'b1, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'h5555, 31'd3, 1'b0, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'haaaa, 31'd3, 1'b1, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'h0000, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'h0000, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'h0000, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'h0000, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_REMOVE, 16'h5555, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_TICK, 16'hffff, 31'h7fffffff, 1'b1));
        rows.push_back(row(dlcq_pkg::OP_REMOVE, 16'hffff, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'h0001, 31'h7fffffff, 1'b0, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_INSERT, 16'h0002, 31'h7fffffff, 1'b0, 1,
                           dlcq_pkg::KIND_INSERTED, 0));
        rows.push_back(row(dlcq_pkg::OP_REMOVE, 16'h0002, '0, 1'b0));
        rows.push_back(row(dlcq_pkg::OP_REMOVE, 16'h0001, '0, 1'b0, 1,
                           dlcq_pkg::KIND_REMOVED, 32'h7fffffff));
        foreach (rows[i])
            send_request(rows[i].op, rows[i].tag, rows[i].delay, rows[i].allow,
                         rows[i].has_fixed, rows[i].fixed);

        // fill the pool and overflow it, then dispatch a large batch
        for (int i = 0; i < dlcq_pkg::QUEUE_DEPTH + 2; i++)
            send_request(dlcq_pkg::OP_INSERT, 16'(16'h0100 + i), 31'($urandom_range(1, 4)),
                         1'b0, 0, '0);
        drain_results();
        for (int i = 0; i < 6; i++) send_request(dlcq_pkg::OP_TICK, '0, '0, i[0], 0, '0);
        drain_results();

        // random: mostly inserts and removes of live tags, ticks mixed in
        n_items = 0;
        while (n_items < 250) begin
            r = $urandom_range(0, 99);
            if (n_items == 160) begin
                drain_results();
                m_stall_on = 1'b0;
            end
            if (n_items == 230) m_stall_on = 1'b1;
            if (r < 38) begin
                tg = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 47));
                case ($urandom_range(0, 7))
                    0: send_request(dlcq_pkg::OP_INSERT, tg, 31'($urandom()), 1'($urandom()),
                                    0, '0);
                    1: send_request(dlcq_pkg::OP_INSERT, tg,
                                    31'h7fffffff - 31'($urandom_range(0, 3)),
                                    1'($urandom()), 0, '0);
                    2: send_request(dlcq_pkg::OP_INSERT, tg, '0, 1'($urandom()), 0, '0);
                    default: send_request(dlcq_pkg::OP_INSERT, tg, 31'($urandom_range(1, 12)),
                                          1'($urandom()), 0, '0);
                endcase
                used_tags.push_back(tg);
            end else if (r < 58) begin
                if (used_tags.size() > 0 && $urandom_range(0, 4) != 0)
                    tg = used_tags[$urandom_range(0, used_tags.size() - 1)];
                else
                    tg = 16'($urandom());
                send_request(dlcq_pkg::OP_REMOVE, tg, 31'($urandom()), 1'($urandom()), 0, '0);
            end else if (r < 97) begin
                send_request(dlcq_pkg::OP_TICK, 16'($urandom()), 31'($urandom()),
                             $urandom_range(0, 2) != 0, 0, '0);
            end else begin
                send_request(dlcq_pkg::OP_RESERVED, 16'($urandom()), 31'($urandom()),
                             1'($urandom()), 0, '0);
                n_items--;
            end
            n_items++;
        end

        // flush what has come due with dispatching ticks
        repeat (40) send_request(dlcq_pkg::OP_TICK, '0, '0, 1'b1, 0, '0);
        drain_results();
        repeat (80) @(negedge aclk);

        $display("Covered %0d results: %0d expirations, %0d removals, %0d pool overflows.",
                 event_count, expired_count, removed_count, overflow_count);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
